@@ rtl/wavelet_row_filter_bank_assert.svh @@
// Assertion macros shared by the wavelet row filter bank RTL.
`ifndef WAVELET_ROW_FILTER_BANK_ASSERT_SVH
`define WAVELET_ROW_FILTER_BANK_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WRFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wavelet row filter bank: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WRFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wavelet row filter bank: next-cycle check failed");

`endif

@@ rtl/wrfb_pkg.sv @@
// Package of widths, reset coefficients and rounding helpers for the row filter bank.
package wrfb_pkg;

  localparam int PIX_W    = 8;
  localparam int COEF_W   = 16;
  localparam int NUM_COEF = 8;
  localparam int IDX_W    = 3;
  localparam int HIST_D   = NUM_COEF - 1;
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int SUM_W    = PROD_W + 3;
  localparam int FRAC_CUT = 7;
  localparam int RND_W    = SUM_W - FRAC_CUT;
  localparam int BAND_W   = 18;
  localparam int OUT_W    = 40;

  // Positions at each row edge that are copied rather than filtered.
  localparam int EDGE = 4;
  // Lag between the incoming pixel and the position being output.
  localparam int LAG = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [BAND_W-1:0] band_t;

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    16'sd7549, 16'sd23424, 16'sd20673, -16'sd917,
    -16'sd6129, 16'sd1011, 16'sd1078, -16'sd347
  };

  // Round Q11.15 to 8 fraction bits (ties up) and saturate to the band range.
  function automatic band_t round_sat(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W-1:0] biased;
    logic signed [RND_W-1:0] r;
    band_t                   res;
    biased = acc + SUM_W'(64);
    r      = RND_W'(biased >>> FRAC_CUT);
    if (r > 20'sd131071) begin
      res = 18'sd131071;
    end else if (r < -20'sd131072) begin
      res = -18'sd131072;
    end else begin
      res = BAND_W'(r);
    end
    return res;
  endfunction

  // A pixel copied into the band format: pixel times 256.
  function automatic band_t pix_copy(input logic [PIX_W-1:0] pix);
    return band_t'({2'b00, pix, 8'h00});
  endfunction

endpackage

@@ rtl/wavelet_row_filter_bank.sv @@
// Row stage of an 8-tap Daubechies wavelet analysis filter bank, one pixel per cycle when not stalled.
// An item passes through the product register and then the result register to the output.
// Throughput: one item per cycle while the output is not stalled; a row-end item holds off
//   the input while it flushes its further edge copies (up to three) through the single issue slot.
// The filter itself is one product stage and one sum-and-round stage.
// Reset (rst, synchronous): coefficients to their defaults, history and position cleared.
`include "wavelet_row_filter_bank_assert.svh"

module wavelet_row_filter_bank #(
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  // Coefficient write port
  input  logic                        cfg_we,
  input  logic [wrfb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [wrfb_pkg::COEF_W-1:0] cfg_data,
  // Pixel input
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [wrfb_pkg::PIX_W-1:0]  s_tdata,   // [7:0] pixel
  input  logic                        s_tlast,   // row_end
  // Result output
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [wrfb_pkg::OUT_W-1:0]  m_tdata,   // [17:0] low_band, [35:18] high_band, zero pad
  output logic                        m_tuser,   // border
  output logic                        m_tlast    // row_last
);

  localparam int POS_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int POS_X = 14;

  wrfb_pkg::coef_t             coef [wrfb_pkg::NUM_COEF];
  logic [wrfb_pkg::PIX_W-1:0]  hist [wrfb_pkg::HIST_D];
  logic [POS_W-1:0]            pos;
  logic [POS_X-1:0]            pos_ext;
  logic [2:0]                  pos_sat;
  logic [1:0]                  first_k;

  logic                        flushing;
  logic [1:0]                  fl_k;
  logic [wrfb_pkg::PIX_W-1:0]  fl_pix [4];
  logic [wrfb_pkg::PIX_W-1:0]  row_pix [4];

  logic                        acc;
  logic                        iss_valid;
  logic                        iss_copy;
  logic                        iss_last;
  logic [wrfb_pkg::PIX_W-1:0]  iss_pix;
  logic [wrfb_pkg::PIX_W-1:0]  win [wrfb_pkg::NUM_COEF];
  wrfb_pkg::prod_t             lo_next [wrfb_pkg::NUM_COEF];
  wrfb_pkg::prod_t             hi_next [wrfb_pkg::NUM_COEF];

  logic                        v1;
  logic                        b1;
  logic                        l1;
  logic [wrfb_pkg::PIX_W-1:0]  p1;
  wrfb_pkg::prod_t             lo_p [wrfb_pkg::NUM_COEF];
  wrfb_pkg::prod_t             hi_p [wrfb_pkg::NUM_COEF];

  logic                        v2;
  wrfb_pkg::band_t             low_band;
  wrfb_pkg::band_t             high_band;
  logic                        border;
  logic                        row_last;
  logic signed [wrfb_pkg::SUM_W-1:0] lo_sum;
  logic signed [wrfb_pkg::SUM_W-1:0] hi_sum;

  logic                        s2_free;
  logic                        s1_free;

  // Stage hand-off: each stage takes a new item when it is empty or drains.
  assign s2_free  = !v2 || m_tready;
  assign s1_free  = !v1 || s2_free;
  assign s_tready = s1_free && !flushing;
  assign acc      = s_tvalid && s_tready;

  // Row position, saturated to the range that decides edge handling.
  assign pos_ext = POS_X'(pos);
  assign pos_sat = (pos_ext >= POS_X'(7)) ? 3'd7 : pos_ext[2:0];
  assign first_k = (pos_sat >= 3'(wrfb_pkg::LAG)) ? 2'd3 : pos_sat[1:0];

  // Pixels k positions back from the current one, k = 0 to 3.
  assign row_pix[0] = s_tdata;
  assign row_pix[1] = hist[0];
  assign row_pix[2] = hist[1];
  assign row_pix[3] = hist[2];

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= wrfb_pkg::COEF_RESET;
    end else if (cfg_we) begin
      coef[cfg_index] <= wrfb_pkg::coef_t'(cfg_data);
    end
  end

  // Pixel history and row position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wrfb_pkg::HIST_D; i++) hist[i] <= '0;
      pos <= '0;
    end else if (acc) begin
      if (s_tlast) begin
        for (int i = 0; i < wrfb_pkg::HIST_D; i++) hist[i] <= '0;
        pos <= '0;
      end else begin
        hist[0] <= s_tdata;
        for (int i = 1; i < wrfb_pkg::HIST_D; i++) hist[i] <= hist[i-1];
        if (pos_ext < POS_X'(MAX_ROW_LENGTH - 1)) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // Row-end flush sequencer: issues the remaining edge copies one a cycle while the product stage is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
      fl_k     <= '0;
    end else if (flushing) begin
      if (s1_free) begin
        if (fl_k == 2'd0) begin
          flushing <= 1'b0;
        end else begin
          fl_k <= fl_k - 2'd1;
        end
      end
    end else if (acc && s_tlast && (first_k != 2'd0)) begin
      flushing <= 1'b1;
      fl_k     <= first_k - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && s_tlast) begin
      fl_pix <= row_pix;
    end
  end

  // Issue: choose the item that enters the product stage this cycle.
  always_comb begin
    iss_valid = 1'b0;
    iss_copy  = 1'b1;
    iss_last  = 1'b0;
    iss_pix   = hist[2];
    if (flushing) begin
      iss_valid = 1'b1;
      iss_pix   = fl_pix[fl_k];
      iss_last  = (fl_k == 2'd0);
    end else if (acc) begin
      if (s_tlast) begin
        iss_valid = 1'b1;
        iss_pix   = row_pix[first_k];
        iss_last  = (first_k == 2'd0);
      end else if (pos_sat >= 3'(wrfb_pkg::LAG)) begin
        iss_valid = 1'b1;
        iss_copy  = (pos_sat < 3'(wrfb_pkg::LAG + wrfb_pkg::EDGE));
      end
    end
  end

  // Filter window (oldest first) and the sixteen tap products.
  always_comb begin
    win[wrfb_pkg::NUM_COEF-1] = s_tdata;
    for (int n = 0; n < wrfb_pkg::HIST_D; n++) begin
      win[n] = hist[wrfb_pkg::HIST_D-1-n];
    end
    for (int n = 0; n < wrfb_pkg::NUM_COEF; n++) begin
      lo_next[n] = wrfb_pkg::prod_t'($signed({1'b0, win[n]})) *
                   wrfb_pkg::prod_t'(coef[wrfb_pkg::NUM_COEF-1-n]);
      hi_next[n] = wrfb_pkg::prod_t'($signed({1'b0, win[n]})) *
                   wrfb_pkg::prod_t'(coef[n]);
      if (n % 2 == 0) begin
        hi_next[n] = -hi_next[n];
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      b1   <= iss_copy;
      l1   <= iss_last;
      p1   <= iss_pix;
      lo_p <= lo_next;
      hi_p <= hi_next;
    end
  end

  // Sum of the eight products per band.
  always_comb begin
    lo_sum = '0;
    hi_sum = '0;
    for (int n = 0; n < wrfb_pkg::NUM_COEF; n++) begin
      lo_sum = lo_sum + wrfb_pkg::SUM_W'(lo_p[n]);
      hi_sum = hi_sum + wrfb_pkg::SUM_W'(hi_p[n]);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && v1) begin
      border   <= b1;
      row_last <= l1;
      if (b1) begin
        low_band  <= wrfb_pkg::pix_copy(p1);
        high_band <= wrfb_pkg::pix_copy(p1);
      end else begin
        low_band  <= wrfb_pkg::round_sat(lo_sum);
        high_band <= wrfb_pkg::round_sat(hi_sum);
      end
    end
  end

  assign m_tvalid = v2;
  assign m_tdata  = {(wrfb_pkg::OUT_W - 2*wrfb_pkg::BAND_W)'(0), high_band, low_band};
  assign m_tuser  = border;
  assign m_tlast  = row_last;

  // Checks on the flush sequencer and the result stream.
  `WRFB_ASSERT_NOW(a_flush_blocks_input, flushing, !s_tready)
  `WRFB_ASSERT_NOW(a_row_last_is_copy, m_tvalid && m_tlast, m_tuser)
  `WRFB_ASSERT_NEXT(a_flush_starts, acc && s_tlast && (first_k != 2'd0), flushing)
  `WRFB_ASSERT_NEXT(a_flush_continues, flushing && s1_free && (fl_k != 2'd0), flushing)
  `WRFB_ASSERT_NEXT(a_issue_lands, iss_valid && s1_free, v1)

endmodule
